/* design/assert_macros.svh */
// Concurrent assertion helpers, clocked on clk, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tmw_pkg.sv */
`timescale 1ns / 1ps

package tmw_pkg;

    localparam int MAX_TEXT_DEF = 256;
    localparam int GAP_DEF      = 4;

    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 2;
    localparam int CFG_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0]  WIN_MAX    = 6'd40;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

    localparam logic [CFG_W-1:0] WIDTH_RST = 6'd16;
    localparam logic [CFG_W-1:0] COL_RST   = 6'd0;
    localparam logic [ROW_W-1:0] ROW_RST   = 2'd0;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_WIDTH = 2'd0,
        CFG_START_COLUMN = 2'd1,
        CFG_DISPLAY_ROW  = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    // Per-character data that travels with a pending memory read.
    typedef struct packed {
        logic             is_text;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             truncated;
    } char_meta_t;

endpackage

/* design/tmw_cmd_if.sv */
`timescale 1ns / 1ps

interface tmw_cmd_if
    import tmw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output opcode, output char_code, input ready);
    modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

/* design/tmw_res_if.sv */
`timescale 1ns / 1ps

interface tmw_res_if
    import tmw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic [COL_W-1:0]  out_column;
    logic [ROW_W-1:0]  out_row;
    logic              window_last;
    logic              text_truncated;

    modport source (output valid, output out_char, output out_column, output out_row,
                    output window_last, output text_truncated, input ready);
    modport sink   (input valid, input out_char, input out_column, input out_row,
                    input window_last, input text_truncated, output ready);
endinterface

/* design/tmw_cfg_if.sv */
`timescale 1ns / 1ps

interface tmw_cfg_if
    import tmw_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/text_marquee_window_unit.sv */
`timescale 1ns / 1ps
// Scrolling text marquee window.
//
// Channels: cmd takes one request per opcode (begin, append a character,
// scroll tick); res delivers one character request per window column; cfg
// writes window_width, start_column and display_row (index 0, 1, 2), and is
// always ready. Write cfg only while the block is idle.
// Begin and append produce nothing. A tick issues min(window_width, 40)
// text-store reads through the single read port of the store, one per
// cycle while the read-result stage has room; the first character reaches
// res through the read-result stage and the output register. With res
// always ready the tick sustains one character per cycle. cmd is ready
// again once the last read of the tick has been issued.
// When res stalls, the output register holds its character and a second
// stage holds the next read result; issue stops until a slot frees up, so
// nothing is lost or reordered.
// Reset clears text length, offset, the truncation flag and the pipeline,
// and loads the register defaults (width 16, column 0, row 0). The text
// store needs no clearing: only entries below the text length are used.
`include "assert_macros.svh"

module text_marquee_window_unit
    import tmw_pkg::*;
#(
    parameter int MAX_TEXT = MAX_TEXT_DEF,
    parameter int GAP      = GAP_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tmw_cmd_if.sink   cmd,
    tmw_res_if.source res,
    tmw_cfg_if.sink   cfg
);

    localparam int LEN_W  = $clog2(MAX_TEXT + 1);
    localparam int LOOP_W = $clog2(MAX_TEXT + GAP + 1);
    localparam int ADDR_W = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

    // Text store: one write port for append, one registered read port for ticks.
    logic [CHAR_W-1:0] mem [MAX_TEXT];
    logic [CHAR_W-1:0] rd_data_reg;

    // Configuration registers.
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] column_reg;
    logic [ROW_W-1:0] row_reg;

    // Scroll state.
    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LOOP_W-1:0]   offset_reg, offset_next;
    logic                ovf_reg, ovf_next;
    logic [LOOP_W-1:0]   pos_reg, pos_next;
    logic [CFG_W-1:0]    k_reg, k_next;
    logic [CFG_W-1:0]    w_reg, w_next;

    // Read-result stage and output register.
    logic        s1_valid_reg, s1_valid_next;
    char_meta_t  s1_meta_reg, s1_meta_next;
    logic        out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    char_meta_t  out_meta_reg, out_meta_next;

    logic              cmd_acc;
    logic              s1_move;
    logic              issue;
    logic              wr_en;
    logic [LOOP_W-1:0] loop_len;
    logic [LOOP_W-1:0] pos_inc;
    logic [LOOP_W-1:0] off_inc;
    logic [CFG_W-1:0]  w_clip;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign loop_len = LOOP_W'(len_reg) + LOOP_W'(GAP);
    assign pos_inc  = pos_reg + 1'b1;
    assign off_inc  = offset_reg + 1'b1;
    assign w_clip   = (width_reg > WIN_MAX) ? WIN_MAX : width_reg;
    assign rd_addr  = pos_reg[ADDR_W-1:0];
    assign wr_addr  = len_reg[ADDR_W-1:0];

    // Move the read result on when the output slot is free or being drained.
    assign s1_move = s1_valid_reg && (!out_valid_reg || res.ready);
    assign issue   = (state_reg == ST_RUN) && (!s1_valid_reg || s1_move);

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        offset_next = offset_reg;
        ovf_next    = ovf_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        w_next      = w_reg;
        wr_en       = 1'b0;

        if (cmd_acc)
        begin
            unique case (cmd.opcode)
                OP_BEGIN:
                begin
                    len_next    = '0;
                    offset_next = '0;
                    ovf_next    = 1'b0;
                end
                OP_APPEND:
                begin
                    if (len_reg < LEN_W'(MAX_TEXT))
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    pos_next = offset_reg;
                    k_next   = '0;
                    w_next   = w_clip;
                    if (w_clip != '0)
                    begin
                        state_next = ST_RUN;
                    end
                    // Advance the offset now; the window walks from the old one.
                    if (loop_len == '0 || off_inc == loop_len)
                    begin
                        offset_next = '0;
                    end
                    else
                    begin
                        offset_next = off_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (issue)
        begin
            k_next   = k_reg + 1'b1;
            pos_next = (pos_inc == loop_len) ? '0 : pos_inc;
            if (k_reg == w_reg - 1'b1)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_meta_next   = s1_meta_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_meta_next  = out_meta_reg;

        if (res.valid && res.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            out_valid_next = 1'b1;
            out_char_next  = s1_meta_reg.is_text ? rd_data_reg : SPACE_CHAR;
            out_meta_next  = s1_meta_reg;
            s1_valid_next  = 1'b0;
        end
        if (issue)
        begin
            s1_valid_next          = 1'b1;
            s1_meta_next.is_text   = (loop_len != '0) && (pos_reg < LOOP_W'(len_reg));
            s1_meta_next.column    = {1'b0, column_reg} + {1'b0, k_reg};
            s1_meta_next.row       = row_reg;
            s1_meta_next.last      = (k_reg == w_reg - 1'b1);
            s1_meta_next.truncated = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            offset_reg    <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            w_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= WIDTH_RST;
            column_reg    <= COL_RST;
            row_reg       <= ROW_RST;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            offset_reg    <= offset_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            w_reg         <= w_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_WINDOW_WIDTH: width_reg  <= cfg.data;
                    CFG_START_COLUMN: column_reg <= cfg.data;
                    CFG_DISPLAY_ROW:  row_reg    <= cfg.data[ROW_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        s1_meta_reg  <= s1_meta_next;
        out_char_reg <= out_char_next;
        out_meta_reg <= out_meta_next;
    end

    // Text store ports; the read data holds while the result stage is stalled.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.char_code;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.out_char       = out_char_reg;
    assign res.out_column     = out_meta_reg.column;
    assign res.out_row        = out_meta_reg.row;
    assign res.window_last    = out_meta_reg.last;
    assign res.text_truncated = out_meta_reg.truncated;

    `ASSERT_CLK(a_offset_in_loop, (loop_len == '0) || (offset_reg < loop_len),
        "scroll offset outside loop")
    `ASSERT_CLK(a_pos_in_loop,
        (state_reg != ST_RUN) || (loop_len == '0) || (pos_reg < loop_len),
        "window position outside loop")
    `ASSERT_CLK(a_len_bound, len_reg <= LEN_W'(MAX_TEXT), "text length above capacity")
    `ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_move, s1_valid_reg,
        "pending read result dropped")

endmodule
